// File: src/s256ks_pkg.sv
// shared types, constants and functions of the keyspace search block
package s256ks_pkg;

   localparam int CAND_LEN = 6;
   localparam logic [28:0] KEYSPACE = 29'd308915776;
   localparam logic [7:0] LETTER_A = 8'h61;
   localparam int NUM_ROUNDS = 64;
   localparam logic [6:0] DRAIN_CYCLES = 7'd70;

   localparam logic [2:0] REG_TARGET0 = 3'd0;
   localparam logic [2:0] REG_TARGET1 = 3'd1;
   localparam logic [2:0] REG_TARGET2 = 3'd2;
   localparam logic [2:0] REG_TARGET3 = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MULT, ST_CHECK, ST_CONV, ST_RUN, ST_DRAIN, ST_FINISH
   } state_type;

   typedef struct packed {
      logic valid;
      logic [28:0] idx;
      logic [47:0] text;
      logic [7:0][31:0] st;
      logic [15:0][31:0] w;
   } stage_type;

   typedef struct packed {
      logic valid;
      logic match;
      logic [28:0] idx;
      logic [47:0] text;
   } hit_type;

   localparam logic [7:0][31:0] H_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [63:0][31:0] RK = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
   };

   function automatic logic [28:0] pow26(input logic [2:0] pos);
      logic [28:0] r;
      case (pos)
         3'd0: r = 29'd11881376;
         3'd1: r = 29'd456976;
         3'd2: r = 29'd17576;
         3'd3: r = 29'd676;
         3'd4: r = 29'd26;
         3'd5: r = 29'd1;
         default: r = 29'd1;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: src/s256ks_round_cell.sv
// one sha-256 round cell with its rolling message schedule window
module s256ks_round_cell
   import s256ks_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic flush,
   input  logic [31:0] rc,
   input  stage_type stage_in,
   output stage_type stage_out
);

   stage_type stage_ff, stage_in_nx;
   logic [31:0] a, b, c, d, e, f, g, h;
   logic [31:0] t1, t2, s0, s1, w_new;

   always_comb begin
      a = stage_in.st[0]; b = stage_in.st[1]; c = stage_in.st[2]; d = stage_in.st[3];
      e = stage_in.st[4]; f = stage_in.st[5]; g = stage_in.st[6]; h = stage_in.st[7];
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + rc + stage_in.w[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      s0 = rotr(stage_in.w[1], 7) ^ rotr(stage_in.w[1], 18) ^ (stage_in.w[1] >> 3);
      s1 = rotr(stage_in.w[14], 17) ^ rotr(stage_in.w[14], 19) ^ (stage_in.w[14] >> 10);
      w_new = stage_in.w[0] + s0 + stage_in.w[9] + s1;
      stage_in_nx = stage_in;
      stage_in_nx.st[0] = t1 + t2;
      stage_in_nx.st[1] = a;
      stage_in_nx.st[2] = b;
      stage_in_nx.st[3] = c;
      stage_in_nx.st[4] = d + t1;
      stage_in_nx.st[5] = e;
      stage_in_nx.st[6] = f;
      stage_in_nx.st[7] = g;
      for (int i = 0; i < 15; i++) begin
         stage_in_nx.w[i] = stage_in.w[i + 1];
      end
      stage_in_nx.w[15] = w_new;
      if (flush) begin
         stage_in_nx.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_nx;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: src/sha256_keyspace_search.sv
// top level of the sha-256 keyspace search block
//
// usage: write the 256-bit target digest through the apb port (four 64-bit
// registers at byte addresses 0, 8, 16, 24) while the block is idle, then
// send a job (shard number, slice length) on the req channel. one result
// per job comes back on the rsp channel.
// a job is taken only when the block is idle; req_stall is high meanwhile.
// processing: setup (multiply, range check), then turning the start index into
// letters, then one candidate per cycle into a 64-cell round chain, then a
// drain of the chain, after which the result goes to rsp. bad arguments
// (negative shard number, zero slice length) and a start index beyond the
// keyspace skip the search and go straight to the result. the search stops at
// the first match, when that candidate's compare at the chain end is registered, and flushes the chain.
// reset clears the target registers to zero and returns the block to idle.
// a stalled result holds on rsp; the next job is taken once it is loaded
// into the output register.
module sha256_keyspace_search
   import s256ks_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_shard_number,
   input  logic [28:0] req_slice_length,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_status,
   output logic rsp_match_found,
   output logic signed [29:0] rsp_match_index,
   output logic [47:0] rsp_match_text,
   output logic [28:0] rsp_attempt_count,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic pready
);

   state_type state_ff, state_in;
   logic [63:0] target_ff [4];
   logic [30:0] shard_ff;
   logic [28:0] slice_ff;
   logic [59:0] start_ff;
   logic [28:0] remain_ff, conv_ff, issue_idx_ff;
   logic [2:0] pos_ff;
   logic [4:0] digit_ff [CAND_LEN];
   logic [4:0] digit_inc [CAND_LEN];
   logic [6:0] drain_ff;
   logic res_status_ff, res_found_ff;
   logic [29:0] res_index_ff;
   logic [47:0] res_text_ff;
   logic [28:0] res_attempts_ff;
   logic rsp_valid_ff, rsp_status_ff, rsp_found_ff;
   logic [29:0] rsp_index_ff;
   logic [47:0] rsp_text_ff;
   logic [28:0] rsp_attempts_ff;
   stage_type chain [NUM_ROUNDS + 1];
   hit_type hit_ff, hit_in;
   logic [47:0] cur_text;
   logic [7:0][31:0] digest;
   logic flush, accept, out_free, cfg_write, carry;
   logic [29:0] end_sum;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cfg_write = psel && penable && pwrite;
   assign pready = 1'b1;
   assign end_sum = {1'b0, start_ff[28:0]} + {1'b0, slice_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            target_ff[i] <= '0;
         end
      end else if (cfg_write) begin
         target_ff[paddr[4:3]] <= pwdata;
      end
   end

   always_comb begin
      case ({1'b0, paddr[4:3]})
         REG_TARGET0: prdata = target_ff[0];
         REG_TARGET1: prdata = target_ff[1];
         REG_TARGET2: prdata = target_ff[2];
         REG_TARGET3: prdata = target_ff[3];
         default: prdata = '0;
      endcase
   end

   // candidate letters and odometer increment
   always_comb begin
      carry = 1'b1;
      for (int i = CAND_LEN - 1; i >= 0; i--) begin
         if (carry && digit_ff[i] == 5'd25) begin
            digit_inc[i] = 5'd0;
         end else begin
            digit_inc[i] = digit_ff[i] + {4'd0, carry};
            carry = 1'b0;
         end
      end
      for (int i = 0; i < CAND_LEN; i++) begin
         cur_text[47 - 8 * i -: 8] = LETTER_A + {3'd0, digit_ff[i]};
      end
   end

   // chain entry
   always_comb begin
      chain[0].valid = (state_ff == ST_RUN);
      chain[0].idx = issue_idx_ff;
      chain[0].text = cur_text;
      chain[0].st = H_INIT;
      chain[0].w = '0;
      chain[0].w[0] = cur_text[47:16];
      chain[0].w[1] = {cur_text[15:0], 8'h80, 8'h00};
      chain[0].w[15] = 32'(CAND_LEN * 8);
   end

   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      s256ks_round_cell u_cell (
         .clock(clock),
         .reset(reset),
         .flush(flush),
         .rc(RK[r]),
         .stage_in(chain[r]),
         .stage_out(chain[r + 1])
      );
   end

   // digest and compare
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[i] = H_INIT[i] + chain[NUM_ROUNDS].st[i];
      end
      hit_in.valid = chain[NUM_ROUNDS].valid && !flush;
      hit_in.match = ({digest[0], digest[1]} == target_ff[0])
                  && ({digest[2], digest[3]} == target_ff[1])
                  && ({digest[4], digest[5]} == target_ff[2])
                  && ({digest[6], digest[7]} == target_ff[3]);
      hit_in.idx = chain[NUM_ROUNDS].idx;
      hit_in.text = chain[NUM_ROUNDS].text;
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (reset) begin
         hit_ff.valid <= 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      flush = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_shard_number[31] || req_slice_length == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MULT;
               end
            end
         end
         ST_MULT: state_in = ST_CHECK;
         ST_CHECK: begin
            if (start_ff >= {31'd0, KEYSPACE}) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (pos_ff == 3'(CAND_LEN)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN, ST_DRAIN: begin
            if (hit_ff.valid && hit_ff.match) begin
               flush = 1'b1;
               state_in = ST_FINISH;
            end else if (state_ff == ST_RUN && remain_ff == 29'd1) begin
               state_in = ST_DRAIN;
            end else if (state_ff == ST_DRAIN && drain_ff == DRAIN_CYCLES) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // job datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            shard_ff <= req_shard_number[30:0];
            slice_ff <= (req_slice_length > KEYSPACE) ? KEYSPACE : req_slice_length;
            res_status_ff <= 1'b1;
            res_found_ff <= 1'b0;
            res_index_ff <= '1;
            res_text_ff <= '0;
            res_attempts_ff <= '0;
         end
         ST_MULT: begin
            start_ff <= shard_ff * slice_ff;
            res_status_ff <= 1'b0;
         end
         ST_CHECK: begin
            conv_ff <= start_ff[28:0];
            issue_idx_ff <= start_ff[28:0];
            remain_ff <= (end_sum < {1'b0, KEYSPACE}) ? slice_ff
                       : KEYSPACE - start_ff[28:0];
            pos_ff <= '0;
            drain_ff <= '0;
            for (int i = 0; i < CAND_LEN; i++) begin
               digit_ff[i] <= '0;
            end
         end
         ST_CONV: begin
            if (pos_ff != 3'(CAND_LEN)) begin
               if (conv_ff >= pow26(pos_ff)) begin
                  conv_ff <= conv_ff - pow26(pos_ff);
                  digit_ff[pos_ff] <= digit_ff[pos_ff] + 5'd1;
               end else begin
                  pos_ff <= pos_ff + 3'd1;
               end
            end
         end
         ST_RUN, ST_DRAIN: begin
            if (state_ff == ST_RUN) begin
               digit_ff <= digit_inc;
               issue_idx_ff <= issue_idx_ff + 29'd1;
               remain_ff <= remain_ff - 29'd1;
            end else begin
               drain_ff <= drain_ff + 7'd1;
            end
            if (hit_ff.valid && hit_ff.match) begin
               res_found_ff <= 1'b1;
               res_index_ff <= {1'b0, hit_ff.idx};
               res_text_ff <= hit_ff.text;
               res_attempts_ff <= hit_ff.idx - start_ff[28:0] + 29'd1;
            end else if (state_ff == ST_RUN) begin
               res_attempts_ff <= res_attempts_ff + 29'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff <= res_found_ff;
         rsp_index_ff <= res_index_ff;
         rsp_text_ff <= res_text_ff;
         rsp_attempts_ff <= res_attempts_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_match_text = rsp_text_ff;
   assign rsp_attempt_count = rsp_attempts_ff;

   a_hit_in_search: assert property (@(posedge clock) disable iff (reset)
      hit_ff.valid |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("chain result outside a search");

   a_found_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match_found) |-> (rsp_attempt_count != '0 && !rsp_status))
      else $error("match reported without attempts");

   a_run_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (remain_ff != '0))
      else $error("issuing with nothing left");

endmodule
